// ===== sv/llsm_pkg.sv =====
package llsm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int MAX_COLS    = 1024;

    localparam int PAT_BYTES = 32;
    localparam int PAT_WORDS = 4;
    localparam int LEN_MAX   = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
    localparam int WIN_DEPTH = LEN_MAX - 1;
    localparam int PAT_IDX_W = $clog2(PAT_BYTES);

    localparam int CH_W    = 8;
    localparam int ROW_W   = 16;
    localparam int LEN_W   = 6;
    localparam int START_W = 10;
    localparam int END_W   = 11;
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int SUM_W   = ((COL_W > START_W) ? COL_W : START_W) + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [CH_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [CH_W-1:0] CASE_OFFSET = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LEN    = 3'd0,
        REG_IGNORE_CASE    = 3'd1,
        REG_PATTERN_WORD_0 = 3'd2,
        REG_PATTERN_WORD_1 = 3'd3,
        REG_PATTERN_WORD_2 = 3'd4,
        REG_PATTERN_WORD_3 = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [CH_W-1:0]         ch;
        logic signed [ROW_W-1:0] line_row;
        logic                    last_in_line;
    } t_in_item;

    typedef struct packed {
        logic signed [ROW_W-1:0] match_row;
        logic [START_W-1:0]      first_col;
        logic [END_W-1:0]        end_col;
    } t_out_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic [CH_W-1:0] fold_byte(input logic [CH_W-1:0] c,
                                                  input logic en);
        logic [CH_W-1:0] r;
        r = c;
        if (en && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ===== sv/literal_line_search_matcher_unit.sv =====
// literal line search matcher
//
// input channel: one text byte per transaction with its row and an
// end-of-line flag; accepted when i_in_valid is high and o_in_stall low
// output channel: one transaction per pattern occurrence (row, start
// column, exclusive end column), reported at the byte that ends it;
// taken when o_out_valid is high and i_out_stall low
// config channel: register index and 64-bit data, taken when i_cfg_valid
// and o_cfg_ready are high; o_cfg_ready is always high
//
// throughput: one byte per cycle while the result queue is not full; the window
// compare of all pattern bytes against the newest bytes happens in the accepting cycle
// a match passes through the result queue and the output register before
// it shows on o_out_valid; a 4-entry result queue sits between the matcher
// and the output register; while the receiver stalls, results collect there
// and the input stalls only once the queue is full
// reset clears all config registers (matching disabled), the column
// counter and the queue; no output is valid after reset
module literal_line_search_matcher_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  llsm_pkg::t_in_item              i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output llsm_pkg::t_out_item             o_out_data,
    input  logic                            i_out_stall,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [llsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [llsm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import llsm_pkg::*;

    t_q_status q_status;
    t_out_item push_data;
    t_out_item head;
    logic      push;
    logic      pop;

    llsm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    llsm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    llsm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== sv/llsm_front.sv =====
module llsm_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  llsm_pkg::t_in_item              i_in_data,
    output logic                            o_in_stall,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [llsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [llsm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  llsm_pkg::t_q_status             i_q_status,
    output logic                            o_push,
    output llsm_pkg::t_out_item             o_push_data
);
    import llsm_pkg::*;

    logic [LEN_W-1:0]      r_pattern_len;
    logic                  r_ignore_case;
    logic [CFG_DATA_W-1:0] r_pattern_word [PAT_WORDS];

    logic [CH_W-1:0]  r_window [WIN_DEPTH];
    logic [COL_W-1:0] r_col;
    logic             r_past_end;

    logic             accept;
    logic [CH_W-1:0]  pat_bytes [PAT_BYTES];
    logic [CH_W-1:0]  txt [LEN_MAX];
    logic             all_eq;
    logic             enabled;
    logic             hit;
    logic [LEN_W-1:0] d;
    logic [SUM_W-1:0] col_end;
    logic [SUM_W-1:0] len_ext;
    logic [SUM_W-1:0] col_start;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_status.full;
    assign accept      = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_len <= '0;
            r_ignore_case <= 1'b0;
            for (int w = 0; w < PAT_WORDS; w++) begin
                r_pattern_word[w] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PATTERN_LEN:    r_pattern_len     <= i_cfg_data[LEN_W-1:0];
                REG_IGNORE_CASE:    r_ignore_case     <= i_cfg_data[0];
                REG_PATTERN_WORD_0: r_pattern_word[0] <= i_cfg_data;
                REG_PATTERN_WORD_1: r_pattern_word[1] <= i_cfg_data;
                REG_PATTERN_WORD_2: r_pattern_word[2] <= i_cfg_data;
                REG_PATTERN_WORD_3: r_pattern_word[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // byte window, newest first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                r_window[i] <= '0;
            end
        end else if (accept) begin
            r_window[0] <= i_in_data.ch;
            for (int i = 1; i < WIN_DEPTH; i++) begin
                r_window[i] <= r_window[i-1];
            end
        end
    end

    // column tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_past_end <= 1'b0;
        end else if (accept) begin
            if (i_in_data.last_in_line) begin
                r_col      <= '0;
                r_past_end <= 1'b0;
            end else if (r_past_end || r_col >= COL_W'(MAX_COLS - 1)) begin
                r_col      <= COL_W'(MAX_COLS - 1);
                r_past_end <= 1'b1;
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < PAT_BYTES; k++) begin
            pat_bytes[k] = r_pattern_word[k >> 3][8 * (k & 7) +: CH_W];
        end
        txt[0] = i_in_data.ch;
        for (int b = 1; b < LEN_MAX; b++) begin
            txt[b] = r_window[b-1];
        end
    end

    // parallel compare, pattern right-aligned on the newest byte
    always_comb begin
        all_eq = 1'b1;
        d      = '0;
        for (int b = 0; b < LEN_MAX; b++) begin
            d = r_pattern_len - LEN_W'(b) - LEN_W'(1);
            if (LEN_W'(b) < r_pattern_len &&
                fold_byte(txt[b], r_ignore_case) !=
                fold_byte(pat_bytes[d[PAT_IDX_W-1:0]], r_ignore_case)) begin
                all_eq = 1'b0;
            end
        end
    end

    always_comb begin
        col_end   = SUM_W'(r_col) + SUM_W'(1);
        len_ext   = SUM_W'(r_pattern_len);
        col_start = col_end - len_ext;
        enabled   = (r_pattern_len != '0) && (r_pattern_len <= LEN_W'(LEN_MAX));
        hit       = enabled && !r_past_end && (col_end >= len_ext) && all_eq;
    end

    assign o_push                = accept && hit;
    assign o_push_data.match_row = i_in_data.line_row;
    assign o_push_data.first_col = col_start[START_W-1:0];
    assign o_push_data.end_col   = col_end[END_W-1:0];

endmodule

// ===== sv/llsm_queue.sv =====
module llsm_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  llsm_pkg::t_out_item  i_push_data,
    input  logic                 i_pop,
    output llsm_pkg::t_out_item  o_head,
    output llsm_pkg::t_q_status  o_status
);
    import llsm_pkg::*;

    t_out_item          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/llsm_back.sv =====
module llsm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  llsm_pkg::t_q_status  i_q_status,
    input  llsm_pkg::t_out_item  i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    output llsm_pkg::t_out_item  o_out_data,
    input  logic                 i_out_stall
);
    import llsm_pkg::*;

    logic      r_valid;
    t_out_item r_data;

    assign o_pop       = !i_q_status.empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head;
        end
    end

endmodule

// ===== sv/llsm_checker.sv =====
module llsm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input llsm_pkg::t_in_item              i_in_data,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input llsm_pkg::t_out_item             o_out_data,
    input logic                            i_out_stall,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [llsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [llsm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import llsm_pkg::*;

    logic [END_W-1:0] span;

    assign span = o_out_data.end_col - END_W'(o_out_data.first_col);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // a result spans between one and the longest pattern
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> span != '0 && span <= END_W'(LEN_MAX))
        else $error("match span out of range");

    // a fresh result after an empty output needs an accepted byte that passed through the queue and the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without a closing byte");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or stall active after reset");

endmodule

bind literal_line_search_matcher_unit llsm_checker u_llsm_checker (.*);
